// File: design/accel_tilt_and_direction_sectors_macros.svh
// Assertion macros for the tilt and direction block.
// Used by design files that check their own logic; needs i_clk and i_rst_n in scope.
`ifndef ACCEL_TILT_AND_DIRECTION_SECTORS_MACROS_SVH
`define ACCEL_TILT_AND_DIRECTION_SECTORS_MACROS_SVH

// check while out of reset
`define ATSD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("atsd check failed");

// check at every edge, reset included
`define ATSD_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("atsd check failed");

`endif

// File: design/atsd_pkg.sv
// Shared widths, constants and angle table for the tilt and direction block.
// No dependencies.
package atsd_pkg;
    localparam int AXW = 16;
    localparam int NW  = 40;
    localparam int RW  = 20;
    localparam int REMW = 22;
    localparam int CW  = 48;
    localparam int AW  = 34;
    localparam int TAB_LEN = 24;

    localparam logic signed [AW-1:0] DEG180_UNITS = AW'(64'sd1179648000);
    localparam logic signed [AW-1:0] DEG360_UNITS = AW'(64'sd2359296000);
    localparam logic signed [AW-1:0] ROUND_HALF   = AW'(64'sd32768);

    localparam logic [15:0] DIR_FULL  = 16'd36000;
    localparam logic [15:0] DIR_60    = 16'd6000;
    localparam logic [15:0] DIR_30    = 16'd3000;
    localparam logic [15:0] DIR_150   = 16'd15000;
    localparam logic [15:0] DIR_120   = 16'd12000;
    localparam logic [15:0] DIR_240   = 16'd24000;
    localparam logic [15:0] DIR_210   = 16'd21000;
    localparam logic [15:0] DIR_330   = 16'd33000;
    localparam logic [15:0] DIR_300   = 16'd30000;

    localparam logic signed [AW-1:0] TILT_MAX = AW'(64'sd9000);
    localparam logic signed [AW-1:0] TILT_MIN = AW'(-64'sd9000);

    localparam logic [7:0] LED_SEC0   = 8'h20;
    localparam logic [7:0] LED_SEC90  = 8'h10;
    localparam logic [7:0] LED_SEC180 = 8'h04;
    localparam logic [7:0] LED_SEC270 = 8'h08;
    localparam logic [7:0] LED_FORCE  = 8'h01;

    localparam logic [31:0] ATAN_UNITS [0:TAB_LEN-1] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
        32'd11730358, 32'd5866610, 32'd2933484, 32'd1466764, 32'd733385,
        32'd366693, 32'd183346, 32'd91673, 32'd45837, 32'd22918,
        32'd11459, 32'd5730, 32'd2865, 32'd1432, 32'd716,
        32'd358, 32'd179, 32'd90, 32'd45
    };
endpackage

// File: design/atsd_if.sv
// Sample and result channels with valid/ready handshake.
// No dependencies.
interface atsd_in_if;
    logic valid;
    logic ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface atsd_out_if;
    logic valid;
    logic ready;
    logic signed [14:0] tilt_centideg;
    logic [15:0]        direction_centideg;
    logic [7:0]         led_port;
    modport source (output valid, output tilt_centideg, output direction_centideg,
                    output led_port, input ready);
    modport sink   (input valid, input tilt_centideg, input direction_centideg,
                    input led_port, output ready);
endinterface

// File: design/atsd_cordic_rot.sv
// One CORDIC vectoring micro-rotation at a fixed shift.
// Depends on atsd_pkg for widths and the arctangent table.
module atsd_cordic_rot #(
    parameter int STEP = 0
) (
    input  logic signed [atsd_pkg::CW-1:0] i_x,
    input  logic signed [atsd_pkg::CW-1:0] i_y,
    input  logic signed [atsd_pkg::AW-1:0] i_acc,
    output logic signed [atsd_pkg::CW-1:0] o_x,
    output logic signed [atsd_pkg::CW-1:0] o_y,
    output logic signed [atsd_pkg::AW-1:0] o_acc
);
    import atsd_pkg::*;

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [AW-1:0] ang;

    always_comb begin
        xs  = i_x >>> STEP;
        ys  = i_y >>> STEP;
        ang = signed'({2'b00, ATAN_UNITS[STEP]});
        if (!i_y[CW-1]) begin
            o_x   = i_x + ys;
            o_y   = i_y - xs;
            o_acc = i_acc + ang;
        end else begin
            o_x   = i_x - ys;
            o_y   = i_y + xs;
            o_acc = i_acc - ang;
        end
    end
endmodule

// File: design/accel_tilt_and_direction_sectors.sv
// Top level: squares, pipelined square root, two CORDIC pipelines, sector byte.
// Depends on atsd_pkg, atsd_if, atsd_cordic_rot and the assertion macro header.
//
// Use:
//   i_sample carries one x, y, z acceleration item; o_result carries the
//   tilt, the direction and the LED port byte for it, in the same order.
//   Every stage holds a valid bit and an item enters in every cycle in which
//   i_sample.ready is high, so one item per cycle is sustained while o_result.ready stays high.
//   From acceptance to o_result.valid an item passes the squares and sum,
//   the square root (one result bit per stage), the CORDIC set-up, the
//   CORDIC_STEPS micro-rotations and the rounding and byte stage.
//   Reset clears all valid bits; no item is in flight afterwards.
//   When the receiver holds ready low, the pipe fills its empty stages and
//   keeps accepting until every stage holds an item; nothing is lost or
//   repeated.
//   CORDIC_STEPS ranges from 8 to 24.
`include "accel_tilt_and_direction_sectors_macros.svh"
module accel_tilt_and_direction_sectors #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    atsd_in_if.sink     i_sample,
    atsd_out_if.source  o_result
);
    import atsd_pkg::*;

    localparam int QD     = RW;
    localparam int S_N    = 2;
    localparam int S_PREP = S_N + QD + 1;
    localparam int S_ROT  = S_PREP + 1;
    localparam int LAST   = S_PREP + CORDIC_STEPS + 1;
    localparam int NST    = LAST + 1;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    always_comb begin
        en[LAST] = !r_v[LAST] || o_result.ready;
        for (int k = LAST - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_sample.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign i_sample.ready = en[0];

    // carry the sample up to the CORDIC set-up
    logic signed [AXW-1:0] r_x [0:S_PREP-1];
    logic signed [AXW-1:0] r_y [0:S_PREP-1];
    logic signed [AXW-1:0] r_z [0:S_PREP-1];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x[0] <= i_sample.accel_x;
            r_y[0] <= i_sample.accel_y;
            r_z[0] <= i_sample.accel_z;
        end
        for (int k = 1; k < S_PREP; k++) begin
            if (en[k]) begin
                r_x[k] <= r_x[k-1];
                r_y[k] <= r_y[k-1];
                r_z[k] <= r_z[k-1];
            end
        end
    end

    // squares, then sum scaled by 256
    logic [30:0] r_xx;
    logic [30:0] r_yy;
    logic signed [31:0] xx_full;
    logic signed [31:0] yy_full;

    assign xx_full = r_x[0] * r_x[0];
    assign yy_full = r_y[0] * r_y[0];

    logic [NW-1:0] r_sn  [0:QD];
    logic [REMW-1:0] r_rem [0:QD];
    logic [RW-1:0] r_res [0:QD];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_xx <= xx_full[30:0];
            r_yy <= yy_full[30:0];
        end
        if (en[S_N]) begin
            r_sn[0]  <= NW'({1'b0, r_xx} + {1'b0, r_yy}) << 8;
            r_rem[0] <= '0;
            r_res[0] <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar j = 0; j < QD; j++) begin : g_sqrt
        logic [REMW+1:0] rem_in;
        logic [REMW+1:0] trial;
        always_comb begin
            rem_in = {r_rem[j], r_sn[j][NW-1-2*j -: 2]};
            trial  = {{(REMW-RW){1'b0}}, r_res[j], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (en[S_N+1+j]) begin
                r_sn[j+1] <= r_sn[j];
                if (rem_in >= trial) begin
                    r_rem[j+1] <= REMW'(rem_in - trial);
                    r_res[j+1] <= {r_res[j][RW-2:0], 1'b1};
                end else begin
                    r_rem[j+1] <= rem_in[REMW-1:0];
                    r_res[j+1] <= {r_res[j][RW-2:0], 1'b0};
                end
            end
        end
    end

    // CORDIC set-up and micro-rotations
    logic signed [CW-1:0] r_tx   [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_ty   [0:CORDIC_STEPS];
    logic signed [AW-1:0] r_tacc [0:CORDIC_STEPS];
    logic                 r_tz   [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_dx   [0:CORDIC_STEPS];
    logic signed [CW-1:0] r_dy   [0:CORDIC_STEPS];
    logic signed [AW-1:0] r_dacc [0:CORDIC_STEPS];
    logic                 r_dz   [0:CORDIC_STEPS];

    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
    logic [AXW-1:0] xp;
    logic [AXW-1:0] yp;
    logic [AXW-1:0] zp;

    always_comb begin
        xp = r_x[S_PREP-1];
        yp = r_y[S_PREP-1];
        zp = r_z[S_PREP-1];
        px = signed'({{(CW-AXW){xp[AXW-1]}}, xp}) <<< 28;
        py = signed'({{(CW-AXW){yp[AXW-1]}}, yp}) <<< 28;
        pz = signed'({{(CW-AXW){zp[AXW-1]}}, zp}) <<< 28;
    end

    always_ff @(posedge i_clk) begin
        if (en[S_PREP]) begin
            r_tx[0]   <= signed'({{(CW-RW){1'b0}}, r_res[QD]}) <<< 24;
            r_ty[0]   <= pz;
            r_tacc[0] <= '0;
            r_tz[0]   <= (zp == '0) && (r_res[QD] == '0);
            r_dz[0]   <= (xp == '0) && (yp == '0);
            if (xp[AXW-1]) begin
                r_dx[0]   <= -px;
                r_dy[0]   <= -py;
                r_dacc[0] <= yp[AXW-1] ? -DEG180_UNITS : DEG180_UNITS;
            end else begin
                r_dx[0]   <= px;
                r_dy[0]   <= py;
                r_dacc[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic signed [AW-1:0] tacc;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [AW-1:0] dacc;

        atsd_cordic_rot #(.STEP(i)) u_tilt (
            .i_x(r_tx[i]), .i_y(r_ty[i]), .i_acc(r_tacc[i]),
            .o_x(tx), .o_y(ty), .o_acc(tacc)
        );
        atsd_cordic_rot #(.STEP(i)) u_dir (
            .i_x(r_dx[i]), .i_y(r_dy[i]), .i_acc(r_dacc[i]),
            .o_x(dx), .o_y(dy), .o_acc(dacc)
        );

        always_ff @(posedge i_clk) begin
            if (en[S_ROT+i]) begin
                r_tx[i+1]   <= tx;
                r_ty[i+1]   <= ty;
                r_tacc[i+1] <= tacc;
                r_tz[i+1]   <= r_tz[i];
                r_dx[i+1]   <= dx;
                r_dy[i+1]   <= dy;
                r_dacc[i+1] <= dacc;
                r_dz[i+1]   <= r_dz[i];
            end
        end
    end

    // round, fold, saturate and build the port byte
    logic signed [AW-1:0] ta;
    logic signed [AW-1:0] tr;
    logic signed [AW-1:0] da;
    logic signed [AW-1:0] dr;
    logic [15:0] d;
    logic [7:0] act;
    logic signed [14:0] n_tilt;
    logic [15:0] n_dir;
    logic [7:0] n_led;

    always_comb begin
        ta = r_tz[CORDIC_STEPS] ? '0 : r_tacc[CORDIC_STEPS];
        tr = (ta + ROUND_HALF) >>> 16;
        if (tr > TILT_MAX) begin
            tr = TILT_MAX;
        end else if (tr < TILT_MIN) begin
            tr = TILT_MIN;
        end
        n_tilt = tr[14:0];

        da = r_dz[CORDIC_STEPS] ? '0 : r_dacc[CORDIC_STEPS];
        if (da[AW-1]) begin
            da = da + DEG360_UNITS;
        end
        dr = (da + ROUND_HALF) >>> 16;
        d  = dr[15:0];
        if (d >= DIR_FULL) begin
            d = d - DIR_FULL;
        end
        n_dir = d;

        act = LED_FORCE;
        if (d >= DIR_300 || d < DIR_60) begin
            act = act | LED_SEC0;
        end
        if (d >= DIR_30 && d < DIR_150) begin
            act = act | LED_SEC90;
        end
        if (d >= DIR_120 && d < DIR_240) begin
            act = act | LED_SEC180;
        end
        if (d >= DIR_210 && d < DIR_330) begin
            act = act | LED_SEC270;
        end
        n_led = ~act | LED_FORCE;
    end

    logic signed [14:0] r_tilt;
    logic [15:0] r_dir;
    logic [7:0] r_led;

    always_ff @(posedge i_clk) begin
        if (en[LAST]) begin
            r_tilt <= n_tilt;
            r_dir  <= n_dir;
            r_led  <= n_led;
        end
    end

    assign o_result.valid              = r_v[LAST];
    assign o_result.tilt_centideg      = r_tilt;
    assign o_result.direction_centideg = r_dir;
    assign o_result.led_port           = r_led;

    `ATSD_ASSERT(a_dir_range, o_result.valid |-> (o_result.direction_centideg < DIR_FULL))
    `ATSD_ASSERT(a_tilt_range, o_result.valid |-> (o_result.tilt_centideg <= 15'sd9000 && o_result.tilt_centideg >= -15'sd9000))
    `ATSD_ASSERT(a_sector_cover, o_result.valid |-> (o_result.led_port[5:2] != 4'b1111))
    `ATSD_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n) |-> !o_result.valid)
endmodule
